[rtl/core/kwem_pkg.sv]
// kwem_pkg: shared constants, codes and the token type for the k-mer window
// extractor. No dependencies.
`timescale 1ns / 1ps

package kwem_pkg;

  // Match table geometry: one chain cell per table slot.
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned SLOT_W      = 6;   // bits of a table slot index
  localparam int unsigned CNT_W       = 7;   // bits of table_count
  localparam int unsigned MAX_KMER    = 32;
  localparam int unsigned MER_W       = 64;
  localparam int unsigned POS_W       = 48;
  localparam int unsigned KSZ_W       = 6;   // bits of kmer_size
  localparam int unsigned RUN_W       = 6;   // bits of the valid-base run
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IN_DATA_W   = 128;
  localparam int unsigned OUT_DATA_W  = 120;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_BASE  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_KMER_SIZE   = 1'b0;
  localparam logic REG_TABLE_COUNT = 1'b1;

  // One request traveling down the cell chain: either a finished window
  // (query) or a table load aimed at one cell.
  typedef struct packed {
    logic              valid;
    logic              is_load;
    logic [MER_W-1:0]  value;    // window value or entry to store
    logic [POS_W-1:0]  pos;
    logic              strand;
    logic [SLOT_W-1:0] slot;     // load target or matching slot
    logic              found;
  } kwem_token_t;

endpackage

[rtl/core/kmer_window_extract_match_top.sv]
// kmer_window_extract_match_top: a request passes the 64-cell match chain and
// the output register; one request per cycle unless a waiting result stalls it.
// Reset clears window, counters, registers and valid flags; table entries
// stay undefined until loaded. Depends on kwem_pkg, kwem_window, kwem_cell.
`timescale 1ns / 1ps

module kmer_window_extract_match_top import kwem_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] base_code, [50:3] start_position, [51] reverse_strand,
  // [57:52] entry_index, [121:58] entry_mer, [127:122] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [OP_W-1:0]       s_axis_tuser,
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [63:0] mer, [111:64] position, [112] strand_out, [118:113] matched_index,
  // [119] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // [0] from_table
  output logic                  m_axis_tuser
);

  logic [KSZ_W-1:0] kmer_size_q;
  logic [CNT_W-1:0] table_count_q;
  logic [CNT_W-1:0] cnt_eff;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_size_q   <= KSZ_W'(1);
      table_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KMER_SIZE:   kmer_size_q   <= cfg_wdata_i[KSZ_W-1:0];
        REG_TABLE_COUNT: table_count_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Clamp the count of entries in use to the table depth.
  assign cnt_eff = (table_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : table_count_q;

  // The whole chain advances together; hold it while a result waits.
  logic        out_valid_q;
  logic        adv;
  logic        accept;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  kwem_token_t chain [TABLE_DEPTH+1];

  kwem_window u_window (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .opcode_i         (s_axis_tuser),
    .base_code_i      (s_axis_tdata[2:0]),
    .start_position_i (s_axis_tdata[50:3]),
    .reverse_strand_i (s_axis_tdata[51]),
    .entry_index_i    (s_axis_tdata[57:52]),
    .entry_mer_i      (s_axis_tdata[121:58]),
    .kmer_size_i      (kmer_size_q),
    .token_o          (chain[0])
  );

  // One cell per slot; a token meets slot 0 first, so the first match found
  // is the lowest slot. Loads ride the chain too, which keeps them in order
  // with the windows around them.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    kwem_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .idx_i   (SLOT_W'(g)),
      .cnt_i   (cnt_eff),
      .token_i (chain[g]),
      .token_o (chain[g+1])
    );
  end

  // Output register: emit windows that match, or every window with no table.
  kwem_token_t tail;
  logic        emit;
  logic [MER_W-1:0]  out_mer_q;
  logic [POS_W-1:0]  out_pos_q;
  logic              out_strand_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_found_q;

  assign tail = chain[TABLE_DEPTH];
  assign emit = tail.valid && !tail.is_load && (cnt_eff == '0 || tail.found);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_mer_q    <= tail.value;
      out_pos_q    <= tail.pos;
      out_strand_q <= tail.strand;
      out_slot_q   <= tail.slot;
      out_found_q  <= tail.found;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_slot_q, out_strand_q, out_pos_q, out_mer_q};
  assign m_axis_tuser  = out_found_q;

endmodule

[rtl/core/kwem_window.sv]
// kwem_window: rolling 2-bit k-mer window, valid-base run, position counter.
// Turns accepted loads and complete windows into chain tokens. Depends on kwem_pkg.
`timescale 1ns / 1ps

module kwem_window import kwem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [CODE_W-1:0] base_code_i,
  input  logic [POS_W-1:0]  start_position_i,
  input  logic              reverse_strand_i,
  input  logic [SLOT_W-1:0] entry_index_i,
  input  logic [MER_W-1:0]  entry_mer_i,
  input  logic [KSZ_W-1:0]  kmer_size_i,
  output kwem_token_t       token_o
);

  logic [MER_W-1:0] window_q, window_d;
  logic [RUN_W-1:0] run_q, run_d;
  logic [POS_W-1:0] offset_q, offset_d;
  logic [POS_W-1:0] count_q, count_d;
  logic             strand_q, strand_d;

  logic [KSZ_W-1:0] k_eff;
  logic [6:0]       shamt;
  logic [MER_W-1:0] mask;

  // Clamp the window size to 1..MAX_KMER.
  always_comb begin
    k_eff = kmer_size_i;
    if (kmer_size_i == '0) begin
      k_eff = KSZ_W'(1);
    end else if (kmer_size_i > KSZ_W'(MAX_KMER)) begin
      k_eff = KSZ_W'(MAX_KMER);
    end
    shamt = 7'(MER_W) - {k_eff, 1'b0};
    mask  = {MER_W{1'b1}} >> shamt;
  end

  always_comb begin
    window_d = window_q;
    run_d    = run_q;
    offset_d = offset_q;
    count_d  = count_q;
    strand_d = strand_q;

    token_o         = '0;
    token_o.strand  = strand_q;

    if (accept_i) begin
      unique case (opcode_i)
        OP_START: begin
          offset_d = start_position_i;
          strand_d = reverse_strand_i;
          count_d  = '0;
          run_d    = '0;
          window_d = '0;
        end
        OP_LOAD: begin
          // A 6-bit slot index always falls inside the table.
          token_o.valid   = 1'b1;
          token_o.is_load = 1'b1;
          token_o.value   = entry_mer_i;
          token_o.slot    = entry_index_i;
        end
        OP_BASE: begin
          count_d = count_q + POS_W'(1);
          if (base_code_i > CODE_W'(3)) begin
            // Error base: drop the window and the run, keep counting.
            window_d = '0;
            run_d    = '0;
          end else begin
            window_d = {window_q[MER_W-3:0], base_code_i[1:0]};
            if (run_q < RUN_W'(MAX_KMER)) begin
              run_d = run_q + RUN_W'(1);
            end
            token_o.valid = (run_d >= k_eff);
            token_o.value = window_d & mask;
            token_o.pos   = offset_q + count_q - POS_W'(k_eff - KSZ_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      run_q    <= '0;
      offset_q <= '0;
      count_q  <= '0;
      strand_q <= 1'b0;
    end else begin
      window_q <= window_d;
      run_q    <= run_d;
      offset_q <= offset_d;
      count_q  <= count_d;
      strand_q <= strand_d;
    end
  end

endmodule

[rtl/core/kwem_cell.sv]
// kwem_cell: one match-table slot. Stores its entry, applies passing loads
// and compares passing windows, then hands the token on. Depends on kwem_pkg.
`timescale 1ns / 1ps

module kwem_cell import kwem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [SLOT_W-1:0] idx_i,
  input  logic [CNT_W-1:0]  cnt_i,
  input  kwem_token_t       token_i,
  output kwem_token_t       token_o
);

  logic [MER_W-1:0] entry_q, entry_d;
  kwem_token_t      token_q, token_d;
  logic             active;

  assign active = {1'b0, idx_i} < cnt_i;

  always_comb begin
    entry_d = entry_q;
    token_d = token_i;
    if (token_i.valid) begin
      if (token_i.is_load) begin
        if (token_i.slot == idx_i) begin
          entry_d = token_i.value;
        end
      end else if (!token_i.found && active && entry_q == token_i.value) begin
        token_d.found = 1'b1;
        token_d.slot  = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q.valid <= 1'b0;
    end else if (en_i) begin
      token_q <= token_d;
    end
  end

  assign token_o = token_q;

endmodule

[dv/tb_kmer_window_extract_match_top.sv]
`timescale 1ns / 1ps
// tb_kmer_window_extract_match_top: self-checking stream testbench for the k-mer
// window extractor with match-table filter. It predicts every window in its own
// model, checks results in order, and depends on kwem_pkg and the RTL top only.

module tb_kmer_window_extract_match_top;
  import kwem_pkg::*;

  // Opcode the block must ignore, and the base codes the stimulus names.
  localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;
  localparam logic [CODE_W-1:0] LAST_BASE_CODE = 3'd3;
  localparam logic [CODE_W-1:0] ERR_BASE_CODE  = 3'd5;
  localparam logic [POS_W-1:0]  POS_MAX        = '1;

  // Pipeline is 65 deep; let it empty with margin before any register write.
  localparam int SETTLE_CYCLES  = 80;
  // Long receiver hold-off, long enough to fill the block and stall its input.
  localparam int HOLD_CYCLES    = 400;
  // Cycles without any accepted request or result before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 3000;

  // One input request, split into its fields.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  start_pos;
    logic              rev;
    logic [SLOT_W-1:0] slot;
    logic [MER_W-1:0]  entry;
  } kmer_req_t;

  // One emitted window as the block should report it.
  typedef struct packed {
    logic [MER_W-1:0]  mer;
    logic [POS_W-1:0]  pos;
    logic              strand;
    logic [SLOT_W-1:0] slot;
    logic              from_table;
  } kmer_hit_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CNT_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [2:0] base_code, [50:3] start_position, [51] reverse_strand,
  // [57:52] entry_index, [121:58] entry_mer, [127:122] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // [1:0] opcode
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [63:0] mer, [111:64] position, [112] strand_out, [118:113] matched_index,
  // [119] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // [0] from_table
  logic                  m_axis_tuser;

  kmer_window_extract_match_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: the testbench's own copy of the registers and the window.
  // ---------------------------------------------------------------------------
  logic [KSZ_W-1:0] k_reg;
  logic [CNT_W-1:0] count_reg;
  logic [MER_W-1:0] win_mer;
  int               valid_run_len;
  logic [POS_W-1:0] seq_base;
  logic [POS_W-1:0] bases_seen;
  logic             seq_strand;
  logic [MER_W-1:0] match_mem [TABLE_DEPTH];

  kmer_hit_t expected_hits_q [$];
  int        err_cnt;

  // Sender and receiver pacing, changed per phase.
  bit gaps_on;
  int burst_left;
  int sink_mode;
  bit hold_off_req;

  // Window length actually used: zero acts as one, anything past the max clamps.
  function automatic int window_len();
    if (k_reg == '0) return 1;
    if (k_reg > KSZ_W'(MAX_KMER)) return int'(MAX_KMER);
    return int'(k_reg);
  endfunction

  // Number of table slots that take part in the compare.
  function automatic int table_span();
    if (count_reg > CNT_W'(TABLE_DEPTH)) return int'(TABLE_DEPTH);
    return int'(count_reg);
  endfunction

  function automatic logic [MER_W-1:0] window_mask(input int k);
    if (k >= 32) return '1;
    return (64'd1 << (2 * k)) - 64'd1;
  endfunction

  // Apply one accepted request to the predictor and queue the window it emits.
  task automatic advance_kmer_model(input kmer_req_t r);
    int        k;
    int        span;
    int        i;
    bit        emit;
    kmer_hit_t hit;
    case (r.op)
      OP_START: begin
        seq_base      = r.start_pos;
        seq_strand    = r.rev;
        bases_seen    = '0;
        valid_run_len = 0;
        win_mer       = '0;
      end
      OP_LOAD: begin
        match_mem[r.slot] = r.entry;
      end
      OP_BASE: begin
        if (r.code > LAST_BASE_CODE) begin
          // Error base: drop the window and the run, keep counting positions.
          win_mer       = '0;
          valid_run_len = 0;
          bases_seen    = bases_seen + POS_W'(1);
        end else begin
          k       = window_len();
          win_mer = {win_mer[MER_W-3:0], r.code[1:0]};
          if (valid_run_len < MAX_KMER) valid_run_len++;
          hit.pos        = seq_base + bases_seen - POS_W'(k - 1);
          bases_seen     = bases_seen + POS_W'(1);
          hit.mer        = win_mer & window_mask(k);
          hit.strand     = seq_strand;
          hit.slot       = '0;
          hit.from_table = 1'b0;
          span = table_span();
          emit = (valid_run_len >= k) && (span == 0);
          if (valid_run_len >= k) begin
            // Lowest matching slot wins.
            for (i = 0; i < span && !hit.from_table; i++) begin
              if (match_mem[SLOT_W'(i)] == hit.mer) begin
                hit.slot       = SLOT_W'(i);
                hit.from_table = 1'b1;
                emit           = 1'b1;
              end
            end
          end
          if (emit) expected_hits_q.push_back(hit);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Random request of the given opcode; fields the opcode does not use are
  // random too so that every field bit toggles.
  function automatic kmer_req_t make_req(input logic [OP_W-1:0] op);
    kmer_req_t r;
    r.op        = op;
    r.code      = CODE_W'($urandom_range(0, 7));
    r.start_pos = POS_W'({$urandom, $urandom});
    r.rev       = 1'($urandom);
    r.slot      = SLOT_W'($urandom);
    r.entry     = {$urandom, $urandom};
    return r;
  endfunction

  // Offer one request and hold it until accepted. Bursts of random length are
  // separated by random gaps when gaps_on is set; valid stays high in a burst.
  task automatic send_req(input kmer_req_t r);
    if (burst_left <= 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= IN_DATA_W'({r.entry, r.slot, r.rev, r.start_pos, r.code});
    do @(posedge clk_i); while (!s_axis_tready);
    advance_kmer_model(r);
    burst_left--;
  endtask

  task automatic send_base(input logic [CODE_W-1:0] code);
    kmer_req_t r;
    r      = make_req(OP_BASE);
    r.code = code;
    send_req(r);
  endtask

  task automatic send_start(input logic [POS_W-1:0] pos, input logic rev);
    kmer_req_t r;
    r           = make_req(OP_START);
    r.start_pos = pos;
    r.rev       = rev;
    send_req(r);
  endtask

  task automatic send_load(input int slot, input logic [MER_W-1:0] value);
    kmer_req_t r;
    r       = make_req(OP_LOAD);
    r.slot  = SLOT_W'(slot);
    r.entry = value;
    send_req(r);
  endtask

  // Drop valid, wait for every expected window, then let the pipeline run dry.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_hits_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write, only ever issued while the block is idle.
  task automatic set_reg(input logic idx, input logic [CNT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == REG_KMER_SIZE) k_reg = val[KSZ_W-1:0];
    else count_reg = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both registers and pick new pacing for the phase that follows.
  task automatic configure(input int k, input int cnt);
    set_reg(REG_KMER_SIZE, CNT_W'(k));
    set_reg(REG_TABLE_COUNT, CNT_W'(cnt));
    gaps_on   = ($urandom_range(0, 3) != 0);
    sink_mode = $urandom_range(0, 3);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, checker, watchdog
  // ---------------------------------------------------------------------------
  // Modes: 0 always ready, 1 mostly ready, 2 fixed 4-of-7 pattern, 3 mostly
  // stalled. A hold-off request forces ready low for HOLD_CYCLES.
  initial begin : sink_ready
    int hold_left;
    int beat;
    hold_left = 0;
    beat      = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (sink_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 99) < 75);
          2:       m_axis_tready <= ((beat % 7) >= 3);
          default: m_axis_tready <= ($urandom_range(0, 99) < 30);
        endcase
      end
      beat++;
    end
  end

  function automatic void check_field(input string what, input logic [MER_W-1:0] want,
                                      input logic [MER_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      err_cnt++;
    end
  endfunction

  // Compare each accepted result with the oldest expected window.
  always @(posedge clk_i) begin : result_check
    kmer_hit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_hits_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual mer %h position %h",
                 $time, m_axis_tdata[63:0], m_axis_tdata[111:64]);
        err_cnt++;
      end else begin
        want = expected_hits_q.pop_front();
        check_field("mer", want.mer, m_axis_tdata[63:0]);
        check_field("position", MER_W'(want.pos), MER_W'(m_axis_tdata[111:64]));
        check_field("strand_out", MER_W'(want.strand), MER_W'(m_axis_tdata[112]));
        check_field("matched_index", MER_W'(want.slot), MER_W'(m_axis_tdata[118:113]));
        check_field("from_table", MER_W'(want.from_table), MER_W'(m_axis_tuser));
      end
    end
  end

  // Abandon the run when neither side moves for too long.
  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings (one base per window, no table): every valid code, error codes,
  // the ignored opcode, a start at the top of the position range so that
  // positions wrap, and a second sequence with the other strand.
  task automatic test_reset_defaults();
    send_start(POS_MAX, 1'b1);
    send_base(3'd0);
    send_base(3'd1);
    send_base(3'd2);
    send_base(3'd3);
    send_req(make_req(OP_UNUSED));
    send_base(3'd4);
    send_base(3'd3);
    send_base(ERR_BASE_CODE);
    send_base(3'd7);
    send_base(3'd2);
    send_start('0, 1'b0);
    send_base(3'd1);
    drain_results();
  endtask

  // Window size zero acts as one; then a two-base window broken by an error.
  task automatic test_window_size_clamp();
    set_reg(REG_KMER_SIZE, '0);
    send_base(3'd2);
    send_base(3'd1);
    drain_results();
    set_reg(REG_KMER_SIZE, CNT_W'(2));
    send_start(POS_W'(5), 1'b1);
    send_base(3'd3);
    send_base(3'd6);
    send_base(3'd1);
    send_base(3'd2);
    send_base(3'd0);
    drain_results();
  endtask

  // Four-slot table with a duplicate entry: hits, misses, lowest slot wins.
  // Load the slots before the count makes them take part in the compare.
  task automatic test_table_match();
    send_load(0, 64'hB);
    send_load(1, 64'h6);
    send_load(2, 64'hB);
    send_load(3, 64'h0);
    drain_results();
    set_reg(REG_TABLE_COUNT, CNT_W'(4));
    send_start(POS_W'(100), 1'b0);
    send_base(3'd2);
    send_base(3'd3);
    send_base(3'd1);
    send_base(3'd2);
    send_base(3'd0);
    send_base(3'd0);
    drain_results();
  endtask

  // Hold the receiver off for a long stretch while bases keep coming, so the
  // block fills and stalls its input, then let it drain.
  task automatic test_backpressure();
    int n;
    configure(1, 0);
    gaps_on      = 1'b0;
    sink_mode    = 0;
    hold_off_req = 1'b1;
    for (n = 0; n < 80; n++) send_base(CODE_W'($urandom_range(0, 3)));
    drain_results();
  endtask

  // Random traffic for the current settings. With a table in use, a quarter of the
  // picks spell a window from a stored entry so that matches actually occur.
  task automatic random_phase(input int n_items);
    int        sent;
    int        pick;
    int        span;
    int        k;
    int        j;
    int        slot_pick;
    kmer_req_t r;
    sent = 0;
    span = table_span();
    k    = window_len();
    if (span != 0) begin
      // Refresh a few slots in the compare range with values that fit the
      // window: zero, all ones, copies of other slots, random windows.
      for (j = 0; j < 6; j++) begin
        slot_pick = $urandom_range(0, span - 1);
        pick      = $urandom_range(0, 7);
        if (pick == 0)      send_load(slot_pick, '0);
        else if (pick == 1) send_load(slot_pick, window_mask(k));
        else if (pick == 2) send_load(slot_pick,
                                      match_mem[SLOT_W'($urandom_range(0, span - 1))]);
        else                send_load(slot_pick, {$urandom, $urandom} & window_mask(k));
      end
    end
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (span != 0 && pick < 25) begin
        slot_pick = $urandom_range(0, span - 1);
        for (j = k - 1; j >= 0; j--) begin
          send_base({1'b0, match_mem[SLOT_W'(slot_pick)][2 * j +: 2]});
        end
        sent += k;
      end else begin
        if (pick < 29) begin
          r = make_req(OP_START);
          if ($urandom_range(0, 3) == 0) r.start_pos = POS_MAX - POS_W'($urandom_range(0, 40));
        end else if (pick < 33) begin
          r      = make_req(OP_BASE);
          r.code = CODE_W'($urandom_range(4, 7));
        end else if (pick < 35) begin
          r = make_req(OP_UNUSED);
        end else if (pick < 38) begin
          r = make_req(OP_LOAD);
          if ($urandom_range(0, 1) == 0) r.entry = r.entry & window_mask(k);
        end else begin
          r      = make_req(OP_BASE);
          r.code = CODE_W'($urandom_range(0, 3));
        end
        send_req(r);
        sent++;
      end
    end
    drain_results();
  endtask

  // Walk through window sizes and table counts, the extremes among them:
  // sizes past the max, counts past the table depth, a single-slot table.
  task automatic test_random_windows();
    int k_plan   [12] = '{1, 32, 63, 0, 5, 2, 3, 32, 8, 16, 0, 0};
    int cnt_plan [12] = '{0, 0, 0, 0, 0, 4, 64, 127, 65, 0, 0, 1};
    int p;
    int s;
    cnt_plan[9]  = $urandom_range(1, 64);
    k_plan[10]   = $urandom_range(0, 63);
    cnt_plan[10] = $urandom_range(0, 127);
    k_plan[11]   = $urandom_range(1, 4);
    // Every slot gets written before any count above four takes effect.
    for (s = 0; s < TABLE_DEPTH; s++) send_load(s, {$urandom, $urandom});
    drain_results();
    for (p = 0; p < 12; p++) begin
      configure(k_plan[p], cnt_plan[p]);
      random_phase(window_len() >= 16 ? 40 : 20);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KMER_SIZE;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_BASE;
    m_axis_tready = 1'b0;
    err_cnt       = 0;
    gaps_on       = 1'b1;
    burst_left    = 0;
    sink_mode     = 1;
    hold_off_req  = 1'b0;
    // Predictor starts from the reset state; the table stays unknown.
    k_reg         = KSZ_W'(1);
    count_reg     = '0;
    win_mer       = '0;
    valid_run_len = 0;
    seq_base      = '0;
    bases_seen    = '0;
    seq_strand    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_window_size_clamp();
    test_table_match();
    test_backpressure();
    test_random_windows();

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/kwem_pkg.sv
rtl/core/kwem_window.sv
rtl/core/kwem_cell.sv
rtl/core/kmer_window_extract_match_top.sv
dv/tb_kmer_window_extract_match_top.sv
